// ----- src/text_contains_or_prefix_match_unit_defines.svh -----
// Assertion helpers shared by the matcher modules.
// Each expects clk and arst_n in the scope of the module that uses it.
`ifndef TEXT_CONTAINS_OR_PREFIX_MATCH_UNIT_DEFINES_SVH
`define TEXT_CONTAINS_OR_PREFIX_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TCPM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcpm: implication check failed");

// Next-cycle implication.
`define TCPM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcpm: next-cycle check failed");

`endif

// ----- src/tcpm_pkg.sv -----
package tcpm_pkg;

	localparam int BYTE_W                   = 8;
	localparam int WORD_W                   = 64;
	localparam int NEEDLE_WORDS             = 4;
	localparam int NEEDLE_BYTES             = NEEDLE_WORDS * WORD_W / BYTE_W;
	localparam int NEEDLE_W                 = NEEDLE_WORDS * WORD_W;
	localparam int LEN_W                    = 6;
	localparam int CFG_IDX_W                = 3;
	localparam int DEFAULT_MAX_NEEDLE_BYTES = 32;

	// seen_q stops counting here
	localparam logic [LEN_W-1:0] SEEN_SAT = LEN_W'(NEEDLE_BYTES);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEEDLE_WORD_0 = 3'd0,
		CFG_NEEDLE_WORD_1 = 3'd1,
		CFG_NEEDLE_WORD_2 = 3'd2,
		CFG_NEEDLE_WORD_3 = 3'd3,
		CFG_NEEDLE_LENGTH = 3'd4,
		CFG_MATCH_MODE    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [NEEDLE_W-1:0] needle;
		logic [LEN_W-1:0]    needle_length;
		logic                match_mode;
	} needle_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              byte_present;
		logic              candidate_end;
	} text_item_t;

endpackage

// ----- src/tcpm_text_if.sv -----
interface tcpm_text_if;
	import tcpm_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              byte_present;
	logic              candidate_end;

	modport source(output valid, text_byte, byte_present, candidate_end, input ready);
	modport sink(input valid, text_byte, byte_present, candidate_end, output ready);
endinterface

// ----- src/tcpm_flag_if.sv -----
interface tcpm_flag_if;
	logic valid;
	logic ready;
	logic candidate_matched;

	modport source(output valid, candidate_matched, input ready);
	modport sink(input valid, candidate_matched, output ready);
endinterface

// ----- src/tcpm_cfg_if.sv -----
interface tcpm_cfg_if;
	import tcpm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- src/text_contains_or_prefix_match_unit.sv -----
// Channel  Dir  Payload                                      Transfer
// text     in   text_byte[7:0], byte_present, candidate_end  valid && ready
// result   out  candidate_matched                            valid && ready
// cfg      in   index[2:0], data[63:0]                       valid && ready (ready tied high)
//
// One text item per cycle, except while the input stalls as described below.
// An input register feeds the needle compare and state update, which writes the result register.
// Input stalls only when a closing item waits in the input register behind an untaken result.
// Reset clears the needle to empty, the mode to contains, and all candidate state.
`include "text_contains_or_prefix_match_unit_defines.svh"

module text_contains_or_prefix_match_unit #(
	parameter int MAX_NEEDLE_BYTES = tcpm_pkg::DEFAULT_MAX_NEEDLE_BYTES
) (
	input  logic         clk,
	input  logic         arst_n,
	tcpm_text_if.sink    text,
	tcpm_flag_if.source  result,
	tcpm_cfg_if.sink     cfg
);
	import tcpm_pkg::*;

	needle_cfg_t needle_cfg;
	text_item_t  item_s1;
	logic        valid_s1;
	logic        step;
	logic        hit;
	logic        res_valid_q;
	logic        res_flag_q;

	tcpm_cfg_regs u_cfg_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.needle_cfg (needle_cfg)
	);

	tcpm_match_core #(
		.MAX_NEEDLE_BYTES (MAX_NEEDLE_BYTES)
	) u_match_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item       (item_s1),
		.needle_cfg (needle_cfg),
		.hit        (hit)
	);

	// hold a closing item while the previous result is still pending
	assign step       = valid_s1 && (!item_s1.candidate_end || !res_valid_q || result.ready);
	assign text.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (text.ready)
			valid_s1 <= text.valid;
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			item_s1.text_byte     <= text.text_byte;
			item_s1.byte_present  <= text.byte_present;
			item_s1.candidate_end <= text.candidate_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (step && item_s1.candidate_end)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && item_s1.candidate_end)
			res_flag_q <= hit;
	end

	assign result.valid             = res_valid_q;
	assign result.candidate_matched = res_flag_q;

	`TCPM_ASSERT_IMP(a_stall_cause, !text.ready,
		valid_s1 && item_s1.candidate_end && res_valid_q && !result.ready)
	`TCPM_ASSERT_NXT(a_result_follows_end, step && item_s1.candidate_end, res_valid_q)
endmodule

// ----- src/tcpm_cfg_regs.sv -----
module tcpm_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	tcpm_cfg_if.sink             cfg,
	output tcpm_pkg::needle_cfg_t needle_cfg
);
	import tcpm_pkg::*;

	logic [NEEDLE_WORDS-1:0][WORD_W-1:0] needle_q;
	logic [LEN_W-1:0]                    length_q;
	logic                                mode_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_q <= '0;
			length_q <= '0;
			mode_q   <= 1'b0;
		end else if (cfg.valid) begin
			// unused indexes are dropped
			unique case (cfg_reg_t'(cfg.index))
				CFG_NEEDLE_WORD_0: needle_q[0] <= cfg.data;
				CFG_NEEDLE_WORD_1: needle_q[1] <= cfg.data;
				CFG_NEEDLE_WORD_2: needle_q[2] <= cfg.data;
				CFG_NEEDLE_WORD_3: needle_q[3] <= cfg.data;
				CFG_NEEDLE_LENGTH: length_q    <= cfg.data[LEN_W-1:0];
				CFG_MATCH_MODE:    mode_q      <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign needle_cfg.needle        = needle_q;
	assign needle_cfg.needle_length = length_q;
	assign needle_cfg.match_mode    = mode_q;
endmodule

// ----- src/tcpm_match_core.sv -----
`include "text_contains_or_prefix_match_unit_defines.svh"

module tcpm_match_core #(
	parameter int MAX_NEEDLE_BYTES = tcpm_pkg::DEFAULT_MAX_NEEDLE_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  tcpm_pkg::text_item_t  item,
	input  tcpm_pkg::needle_cfg_t needle_cfg,
	output logic                  hit
);
	import tcpm_pkg::*;

	localparam int CAP = (MAX_NEEDLE_BYTES < NEEDLE_BYTES) ? MAX_NEEDLE_BYTES : NEEDLE_BYTES;

	logic [CAP-1:0]   partial_q;
	logic             found_q;
	logic [LEN_W-1:0] seen_q;
	logic             prefix_eq_q;

	logic [LEN_W-1:0] len;
	logic [CAP-1:0]   eq_raw;
	logic [CAP-1:0]   in_len;
	logic [CAP-1:0]   at_pos;
	logic [CAP-1:0]   top_sel;
	logic [CAP-1:0]   partial_next;
	logic             found_next;
	logic [LEN_W-1:0] seen_next;
	logic             prefix_eq_next;

	assign len = (needle_cfg.needle_length > LEN_W'(CAP)) ? LEN_W'(CAP)
		: needle_cfg.needle_length;

	// compare the byte against every needle position at once
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			eq_raw[i]  = needle_cfg.needle[i*BYTE_W +: BYTE_W] == item.text_byte;
			in_len[i]  = LEN_W'(i) < len;
			at_pos[i]  = seen_q == LEN_W'(i);
			top_sel[i] = len == LEN_W'(i + 1);
		end
	end

	always_comb begin
		partial_next   = partial_q;
		found_next     = found_q;
		seen_next      = seen_q;
		prefix_eq_next = prefix_eq_q;
		if (item.byte_present) begin
			partial_next   = ((partial_q << 1) | CAP'(1)) & eq_raw & in_len;
			found_next     = found_q | (|(partial_next & top_sel));
			prefix_eq_next = prefix_eq_q & ~(|(at_pos & in_len & ~eq_raw));
			if (seen_q < SEEN_SAT)
				seen_next = seen_q + LEN_W'(1);
		end
	end

	always_comb begin
		if (len == '0)
			hit = 1'b1;
		else if (needle_cfg.match_mode)
			hit = prefix_eq_next && (seen_next >= len);
		else
			hit = found_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			found_q     <= 1'b0;
			seen_q      <= '0;
			prefix_eq_q <= 1'b1;
		end else if (step) begin
			if (item.candidate_end) begin
				// candidate closed: start the next one clean
				partial_q   <= '0;
				found_q     <= 1'b0;
				seen_q      <= '0;
				prefix_eq_q <= 1'b1;
			end else begin
				partial_q   <= partial_next;
				found_q     <= found_next;
				seen_q      <= seen_next;
				prefix_eq_q <= prefix_eq_next;
			end
		end
	end

	`TCPM_ASSERT_NXT(a_clear_after_end, step && item.candidate_end,
		partial_q == '0 && !found_q && seen_q == '0 && prefix_eq_q)
	`TCPM_ASSERT_IMP(a_seen_saturates, 1'b1, seen_q <= SEEN_SAT)
	`TCPM_ASSERT_IMP(a_found_needs_bytes, found_q, seen_q != '0)
endmodule

// ----- tb/text_contains_or_prefix_match_unit_tb.sv -----
module text_contains_or_prefix_match_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcpm_pkg::*;

	localparam int NEEDLE_CAP = (DEFAULT_MAX_NEEDLE_BYTES < 32) ? DEFAULT_MAX_NEEDLE_BYTES : 32;
	localparam int PIPE_DRAIN = 4;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 275;
	localparam int MAX_REPORTS = 10;

	// indexes outside the register map, written to show they are ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

	class match_flag_tracker;
		logic [NEEDLE_W-1:0] needle;
		logic [LEN_W-1:0]    needle_len;
		logic                mode;
		logic [31:0]         partial;
		bit                  found;
		int unsigned         seen;
		bit                  prefix_eq;
		bit                  flags_due[$];
		int                  errors;

		function new();
			needle = '0;
			needle_len = '0;
			mode = 1'b0;
			errors = 0;
			clear_candidate();
		endfunction

		function void clear_candidate();
			partial = '0;
			found = 1'b0;
			seen = 0;
			prefix_eq = 1'b1;
		endfunction

		function int unsigned eff_len();
			int unsigned n;
			n = needle_len;
			return (n > NEEDLE_CAP) ? NEEDLE_CAP : n;
		endfunction

		function logic [7:0] needle_at(int unsigned i);
			return needle[(i % 32) * 8 +: 8];
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] d);
			case (idx)
				CFG_NEEDLE_WORD_0: needle[0*WORD_W +: WORD_W] = d;
				CFG_NEEDLE_WORD_1: needle[1*WORD_W +: WORD_W] = d;
				CFG_NEEDLE_WORD_2: needle[2*WORD_W +: WORD_W] = d;
				CFG_NEEDLE_WORD_3: needle[3*WORD_W +: WORD_W] = d;
				CFG_NEEDLE_LENGTH: needle_len = d[LEN_W-1:0];
				CFG_MATCH_MODE:    mode = d[0];
				default: ;
			endcase
		endfunction

		function void note_text(logic [7:0] b, logic present, logic last);
			logic [31:0] eq;
			int unsigned n;
			bit hit;
			n = eff_len();
			eq = '0;
			if (present) begin
				for (int i = 0; i < n; i++)
					if (needle_at(i) == b)
						eq[i] = 1'b1;
				partial = ((partial << 1) | 32'd1) & eq;
				if (n > 0 && partial[n-1])
					found = 1'b1;
				if (seen < n && needle_at(seen) != b)
					prefix_eq = 1'b0;
				if (seen < 32)
					seen++;
			end
			if (last) begin
				if (n == 0)
					hit = 1'b1;
				else if (mode)
					hit = prefix_eq && (seen >= n);
				else
					hit = found;
				flags_due = {flags_due, hit};
				clear_candidate();
			end
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%s", msg);
		endfunction

		function void check_flag(logic got);
			bit want;
			if (flags_due.size() == 0) begin
				report($sformatf("unexpected result transfer: matched=%b", got));
				return;
			end
			want = flags_due.pop_front();
			if (got !== want)
				report($sformatf("candidate_matched mismatch: expected %0b actual %b", want, got));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   send_idle_pct = 17;
	int   recv_idle_pct = 86;

	match_flag_tracker sb;

	tcpm_text_if text_ch();
	tcpm_flag_if flag_ch();
	tcpm_cfg_if  cfg_ch();

	text_contains_or_prefix_match_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (flag_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		flag_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (flag_ch.valid && flag_ch.ready)
				sb.check_flag(flag_ch.candidate_matched);
			if (text_ch.valid && text_ch.ready)
				sb.note_text(text_ch.text_byte, text_ch.byte_present, text_ch.candidate_end);
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_reg(cfg_ch.index, cfg_ch.data);
		end
	end

	// end the run when no channel has moved a transfer for too long
	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((text_ch.valid && text_ch.ready) || (flag_ch.valid && flag_ch.ready) ||
			    (cfg_ch.valid && cfg_ch.ready))
				stall = 0;
			else
				stall++;
		end
		$display("tb: failure");
		$finish;
	end

	task automatic send_text_item(logic [7:0] b, logic present, logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			text_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		text_ch.valid         <= 1'b1;
		text_ch.text_byte     <= b;
		text_ch.byte_present  <= present;
		text_ch.candidate_end <= last;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
	endtask

	// drop valid, let every pending flag out, then let the pipeline settle
	task automatic wait_idle();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.flags_due.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic write_cfg_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	task automatic close_cfg_write();
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] alpha_byte();
		case ($urandom_range(3))
			0: return 8'h61;
			1: return 8'h62;
			2: return 8'h00;
			default: return 8'hFF;
		endcase
	endfunction

	function automatic logic [7:0] pick_text_byte();
		int unsigned n;
		int unsigned r;
		n = sb.eff_len();
		r = $urandom_range(99);
		if (r < 55 && n > 0)
			return sb.needle_at($urandom_range(n - 1));
		else if (r < 80)
			return alpha_byte();
		else
			return 8'($urandom_range(255));
	endfunction

	task automatic setup_phase(int ph);
		logic [WORD_W-1:0] w;
		logic [LEN_W-1:0]  len;
		logic              md;
		logic [CFG_IDX_W-1:0] idx;
		for (int k = 0; k < NEEDLE_WORDS; k++) begin
			if (ph == 0 || ph == 3 || ph == 4) begin
				w = rand_word();
			end else begin
				for (int j = 0; j < 8; j++)
					w[j*8 +: 8] = alpha_byte();
			end
			idx = CFG_IDX_W'(k);
			write_cfg_reg(idx, w);
		end
		case (ph)
			0: len = 6'd1;
			1: len = 6'd32;
			2: len = 6'd0;
			3: len = 6'd63;
			4: len = 6'($urandom_range(2, 8));
			default: len = 6'($urandom_range(63));
		endcase
		md = (ph == 1 || ph == 2 || ph == 5);
		w = rand_word();
		write_cfg_reg(CFG_NEEDLE_LENGTH, {w[WORD_W-1:LEN_W], len});
		w = rand_word();
		write_cfg_reg(CFG_MATCH_MODE, {w[WORD_W-1:1], md});
		close_cfg_write();
	endtask

	task automatic random_candidate(ref int count);
		logic [7:0] bytes_q[$];
		logic [7:0] b;
		int unsigned n;
		int unsigned k;
		int chunks;
		bit end_absent;
		bit last;
		n = sb.eff_len();
		if ($urandom_range(99) < 5) begin
			send_text_item(8'($urandom_range(255)), 1'b0, 1'b1);
			count++;
			return;
		end
		chunks = $urandom_range(1, 3);
		for (int c = 0; c < chunks; c++) begin
			if ($urandom_range(1)) begin
				k = $urandom_range(1) ? n : $urandom_range(n);
				for (int j = 0; j < k; j++) begin
					b = sb.needle_at(j);
					if ($urandom_range(99) < 4)
						b = pick_text_byte();
					bytes_q = {bytes_q, b};
				end
			end else begin
				k = $urandom_range(5);
				for (int j = 0; j < k; j++)
					bytes_q = {bytes_q, pick_text_byte()};
			end
		end
		while (bytes_q.size() > 48)
			void'(bytes_q.pop_back());
		if (bytes_q.size() == 0)
			bytes_q = {bytes_q, pick_text_byte()};
		end_absent = ($urandom_range(99) < 15);
		foreach (bytes_q[i]) begin
			// a byte-less item inside a candidate changes nothing
			if ($urandom_range(99) < 8) begin
				send_text_item(8'($urandom_range(255)), 1'b0, 1'b0);
				count++;
			end
			last = (i == bytes_q.size() - 1) && !end_absent;
			send_text_item(bytes_q[i], 1'b1, last);
			count++;
		end
		if (end_absent) begin
			send_text_item(8'($urandom_range(255)), 1'b0, 1'b1);
			count++;
		end
	endtask

	initial begin
		int sent;
		bit paused;
		sb = new();
		text_ch.valid         <= 1'b0;
		text_ch.text_byte     <= '0;
		text_ch.byte_present  <= 1'b0;
		text_ch.candidate_end <= 1'b0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.index          <= '0;
		cfg_ch.data           <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty needle matches everything, even an empty candidate
		send_text_item(8'h00, 1'b0, 1'b1);
		send_text_item(8'hFF, 1'b1, 1'b1);
		wait_idle();

		// needle 00 FF 41, upper register bits carry junk
		write_cfg_reg(CFG_NEEDLE_WORD_0, 64'hA5A5_C3C3_9641_FF00);
		write_cfg_reg(CFG_NEEDLE_WORD_1, '1);
		write_cfg_reg(CFG_NEEDLE_WORD_2, '0);
		write_cfg_reg(CFG_NEEDLE_WORD_3, '1);
		write_cfg_reg(CFG_NEEDLE_LENGTH, 64'hFFFF_FFFF_FFFF_FFC3);
		write_cfg_reg(CFG_MATCH_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
		write_cfg_reg(CFG_SPARE_6, '1);
		write_cfg_reg(CFG_SPARE_7, '1);
		close_cfg_write();

		send_text_item(8'h41, 1'b1, 1'b0);
		send_text_item(8'h00, 1'b1, 1'b0);
		send_text_item(8'h5C, 1'b0, 1'b0);
		send_text_item(8'hFF, 1'b1, 1'b0);
		send_text_item(8'h41, 1'b1, 1'b1);
		send_text_item(8'h00, 1'b0, 1'b1);
		// a match split across two candidates must not count
		send_text_item(8'h00, 1'b1, 1'b0);
		send_text_item(8'hFF, 1'b1, 1'b1);
		send_text_item(8'h41, 1'b1, 1'b1);

		// switch to prefix mode in the middle of a candidate
		send_text_item(8'h00, 1'b1, 1'b0);
		wait_idle();
		write_cfg_reg(CFG_MATCH_MODE, 64'd1);
		close_cfg_write();
		send_text_item(8'hFF, 1'b1, 1'b0);
		send_text_item(8'h41, 1'b1, 1'b0);
		send_text_item(8'h12, 1'b1, 1'b1);
		send_text_item(8'h00, 1'b1, 1'b0);
		send_text_item(8'hFF, 1'b1, 1'b1);
		wait_idle();

		// overlong needle saturates to 32 bytes
		for (int k = 0; k < NEEDLE_WORDS; k++)
			write_cfg_reg(CFG_IDX_W'(k), {8{8'h5A}});
		write_cfg_reg(CFG_NEEDLE_LENGTH, 64'd63);
		close_cfg_write();
		for (int j = 0; j < 32; j++)
			send_text_item(8'h5A, 1'b1, j == 31);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph / 2)
				0: begin
					send_idle_pct = 17;
					recv_idle_pct = 86;
				end
				1: begin
					send_idle_pct = 86;
					recv_idle_pct = 17;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			wait_idle();
			setup_phase(ph);
			sent = 0;
			paused = 1'b0;
			while (sent < PHASE_ITEMS) begin
				random_candidate(sent);
				if (ph == 0 && !paused && sent > PHASE_ITEMS / 2) begin
					// hold until every pending flag is out
					text_ch.valid <= 1'b0;
					@(posedge clk);
					while (sb.flags_due.size() != 0)
						@(posedge clk);
					paused = 1'b1;
				end
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
